@@ rtl/cfc_pkg.sv @@
`timescale 1ns / 1ps
// cfc_pkg: shared types, constants and the CRC-16-CCITT byte update for the
// CRC-16 frame checker. No dependencies.
package cfc_pkg;

  localparam int BYTE_W   = 8;
  localparam int CRC_W    = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNC     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_MAGIC = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_VER   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CRC_ERR   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXP_TYPE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_EN  = 3'd4;

  localparam logic [BYTE_W-1:0] MAGIC_RST    = 8'd0;
  localparam logic [BYTE_W-1:0] VERSION_RST  = 8'd1;
  localparam logic [BYTE_W-1:0] EXP_LEN_RST  = 8'd26;
  localparam logic [BYTE_W-1:0] EXP_TYPE_RST = 8'd0;

  localparam logic [BYTE_W-1:0] MIN_LEN = 8'd3;
  localparam logic [BYTE_W-1:0] CNT_MAX = 8'hFF;

  typedef struct packed {
    logic [BYTE_W-1:0] magic_value;
    logic [BYTE_W-1:0] version_value;
    logic [BYTE_W-1:0] expected_len;
    logic [BYTE_W-1:0] expected_type;
    logic              type_check_en;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   frame_type;
    logic [BYTE_W-1:0]   frame_len;
    logic [CRC_W-1:0]    computed_crc;
  } res_t;

  // MSB first, no reflection
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if ((c & CRC_TOP) != '0) c = (c << 1) ^ CRC_POLY;
      else c = c << 1;
    end
    return c;
  endfunction

endpackage

@@ rtl/cfc_in_if.sv @@
`timescale 1ns / 1ps
// cfc_in_if: byte stream channel into the frame checker.
// Depends on cfc_pkg.
interface cfc_in_if;
  logic                      valid;
  logic                      ready;
  logic [cfc_pkg::BYTE_W-1:0] data_byte;
  logic                      last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/cfc_out_if.sv @@
`timescale 1ns / 1ps
// cfc_out_if: frame verdict channel out of the frame checker.
// Depends on cfc_pkg.
interface cfc_out_if;
  logic                         valid;
  logic                         ready;
  logic [cfc_pkg::STATUS_W-1:0] status;
  logic [cfc_pkg::BYTE_W-1:0]   frame_type;
  logic [cfc_pkg::BYTE_W-1:0]   frame_len;
  logic [cfc_pkg::CRC_W-1:0]    computed_crc;

  modport source (output valid, output status, output frame_type, output frame_len,
                  output computed_crc, input ready);
  modport sink   (input valid, input status, input frame_type, input frame_len,
                  input computed_crc, output ready);
endinterface

@@ rtl/cfc_cfg_regs.sv @@
`timescale 1ns / 1ps
// cfc_cfg_regs: configuration register file written through the plain
// write port. Depends on cfc_pkg.
module cfc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cfc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [cfc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output cfc_pkg::cfg_t                   cfg
);
  import cfc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic_value   <= MAGIC_RST;
      cfg_r.version_value <= VERSION_RST;
      cfg_r.expected_len  <= EXP_LEN_RST;
      cfg_r.expected_type <= EXP_TYPE_RST;
      cfg_r.type_check_en <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_MAGIC:    cfg_r.magic_value   <= cfg_wdata;
        REG_VERSION:  cfg_r.version_value <= cfg_wdata;
        REG_EXP_LEN:  cfg_r.expected_len  <= cfg_wdata;
        REG_EXP_TYPE: cfg_r.expected_type <= cfg_wdata;
        REG_TYPE_EN:  cfg_r.type_check_en <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/cfc_frame_track.sv @@
`timescale 1ns / 1ps
// cfc_frame_track: per-frame state (count, CRC, header checks, received CRC)
// and the end-of-frame verdict. Depends on cfc_pkg.
module cfc_frame_track (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [cfc_pkg::BYTE_W-1:0]  data_byte,
  input  logic                        last_byte,
  input  cfc_pkg::cfg_t               cfg,
  output cfc_pkg::res_t               res
);
  import cfc_pkg::*;

  logic [BYTE_W-1:0] cnt_r, cnt_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic              magic_ok_r, magic_ok_nxt;
  logic              ver_ok_r, ver_ok_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [CRC_W-1:0]  rx_crc_r, rx_crc_nxt;
  logic [BYTE_W-1:0] eff_len;
  logic              len_on;

  always_comb begin
    eff_len = cfg.expected_len;
    if (cfg.expected_len == 8'd1 || cfg.expected_len == 8'd2) eff_len = MIN_LEN;
    len_on = (eff_len != '0);

    magic_ok_nxt = (cnt_r == 8'd0) ? (data_byte == cfg.magic_value) : magic_ok_r;
    ver_ok_nxt   = (cnt_r == 8'd1) ? (data_byte == cfg.version_value) : ver_ok_r;
    type_nxt     = (cnt_r == 8'd2) ? data_byte : type_r;

    crc_nxt    = crc_r;
    rx_crc_nxt = rx_crc_r;
    if (len_on) begin
      if (cnt_r < eff_len - 8'd2) crc_nxt = crc_byte(crc_r, data_byte);
      else if (cnt_r == eff_len - 8'd2) rx_crc_nxt = {rx_crc_r[15:8], data_byte};
      else if (cnt_r == eff_len - 8'd1) rx_crc_nxt = {data_byte, rx_crc_r[7:0]};
    end

    cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 8'd1;

    if (cnt_nxt < MIN_LEN) res.status = ST_TRUNC;
    else if (!magic_ok_nxt) res.status = ST_BAD_MAGIC;
    else if (!ver_ok_nxt) res.status = ST_BAD_VER;
    else if (len_on && cnt_nxt < eff_len) res.status = ST_TRUNC;
    else if (len_on && crc_nxt != rx_crc_nxt) res.status = ST_CRC_ERR;
    else if (cfg.type_check_en && type_nxt != cfg.expected_type) res.status = ST_BAD_TYPE;
    else res.status = ST_OK;

    res.frame_type   = type_nxt;
    res.frame_len    = cnt_nxt;
    res.computed_crc = crc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      cnt_r      <= '0;
      crc_r      <= CRC_INIT;
      magic_ok_r <= 1'b0;
      ver_ok_r   <= 1'b0;
      type_r     <= '0;
      rx_crc_r   <= '0;
    end else if (step) begin
      cnt_r      <= cnt_nxt;
      crc_r      <= crc_nxt;
      magic_ok_r <= magic_ok_nxt;
      ver_ok_r   <= ver_ok_nxt;
      type_r     <= type_nxt;
      rx_crc_r   <= rx_crc_nxt;
    end
  end

endmodule

@@ rtl/crc16_frame_checker.sv @@
`timescale 1ns / 1ps
// crc16_frame_checker: byte-stream frame checker with CRC-16-CCITT.
// A last byte's verdict is valid once it has passed the input register and then the verdict register.
// Throughput: one byte per cycle; the CRC byte update is combinational.
// A verdict not taken stalls only last-byte steps behind it.
// Reset (synchronous, rst_n low) clears frame state, both stages and restores
// register defaults. Depends on cfc_pkg, cfc_in_if, cfc_out_if and submodules.
module crc16_frame_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  cfc_in_if.sink                          in_if,
  cfc_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [cfc_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [cfc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cfc_pkg::*;

  cfg_t              cfg;
  res_t              res;
  res_t              out_res_r;
  logic              out_valid_r, out_valid_nxt;
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_last_r;
  logic              step;
  logic              in_xfer;

  cfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cfc_frame_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .cfg       (cfg),
    .res       (res)
  );

  // non-last bytes never wait on the result slot
  assign step     = in_valid_r && (!in_last_r || !out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || step;
  assign in_xfer  = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) in_valid_r <= 1'b0;
    else if (in_if.ready) in_valid_r <= in_if.valid;
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_byte_r <= in_if.data_byte;
      in_last_r <= in_if.last_byte;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_if.ready;
    if (step && in_last_r) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (step && in_last_r) out_res_r <= res;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_res_r.status;
  assign out_if.frame_type   = out_res_r.frame_type;
  assign out_if.frame_len    = out_res_r.frame_len;
  assign out_if.computed_crc = out_res_r.computed_crc;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_last_r) |-> (!out_valid_r || out_if.ready))
    else $error("verdict overwrote an untaken result");

  a_verdict_shown: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_last_r) |=> out_if.valid)
    else $error("last byte gave no verdict");

  a_short_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.frame_len < MIN_LEN) |-> (out_if.status == ST_TRUNC))
    else $error("short frame not reported truncated");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.status == ST_OK || out_if.status == ST_TRUNC ||
                      out_if.status == ST_BAD_MAGIC || out_if.status == ST_BAD_VER ||
                      out_if.status == ST_CRC_ERR || out_if.status == ST_BAD_TYPE))
    else $error("status code out of range");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking testbench for crc16_frame_checker. Streams directed and
// random frames, predicts each frame verdict and compares it field by field.
// Depends on cfc_pkg, cfc_in_if, cfc_out_if and the checker RTL.
module tb_top;
  import cfc_pkg::*;

  localparam int IDX_TOP    = (1 << CFG_IDX_W) - 1;
  localparam int QUIET_CYC  = 4;
  localparam int PHASE_ITEMS = 65;
  localparam int NUM_PHASES  = 8;

  typedef logic [BYTE_W-1:0] byte_q_t[$];
  typedef enum int {FLT_NONE, FLT_BIT, FLT_MAGIC, FLT_VER, FLT_TYPE, FLT_NOISE} fault_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cfc_in_if  in_ch();
  cfc_out_if out_ch();

  crc16_frame_checker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // register shadow
  logic [BYTE_W-1:0] cfg_magic   = MAGIC_RST;
  logic [BYTE_W-1:0] cfg_ver     = VERSION_RST;
  logic [BYTE_W-1:0] cfg_len     = EXP_LEN_RST;
  logic [BYTE_W-1:0] cfg_type    = EXP_TYPE_RST;
  logic              cfg_type_en = 1'b0;

  // frame tracking state
  logic [BYTE_W-1:0] frm_cnt   = '0;
  logic [CRC_W-1:0]  frm_crc   = CRC_INIT;
  logic              magic_hit = 1'b0;
  logic              ver_hit   = 1'b0;
  logic [BYTE_W-1:0] frm_type  = '0;
  logic [CRC_W-1:0]  rx_fcs    = '0;

  res_t verdict_q[$];
  int   err_cnt      = 0;
  int   bytes_sent   = 0;
  int   verdicts_seen = 0;
  int   cfg_writes   = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;

  function automatic logic [CRC_W-1:0] crc_next(input logic [CRC_W-1:0] c,
                                                input logic [BYTE_W-1:0] b);
    logic fb;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      fb = c[CRC_W-1] ^ b[i];
      c  = {c[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

  function automatic int unsigned span_len();
    if (cfg_len == 8'd1 || cfg_len == 8'd2) return MIN_LEN;
    return cfg_len;
  endfunction

  task automatic track_frame_byte(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned pos;
    int unsigned e;
    res_t r;
    pos = frm_cnt;
    e   = span_len();
    if (pos == 0) magic_hit = (b == cfg_magic);
    if (pos == 1) ver_hit = (b == cfg_ver);
    if (pos == 2) frm_type = b;
    if (e != 0) begin
      if (pos < e - 2) frm_crc = crc_next(frm_crc, b);
      else if (pos == e - 2) rx_fcs[7:0] = b;
      else if (pos == e - 1) rx_fcs[15:8] = b;
    end
    if (frm_cnt != CNT_MAX) frm_cnt = frm_cnt + 1'b1;
    if (last) begin
      if (frm_cnt < MIN_LEN) r.status = ST_TRUNC;
      else if (!magic_hit) r.status = ST_BAD_MAGIC;
      else if (!ver_hit) r.status = ST_BAD_VER;
      else if (e != 0 && frm_cnt < e) r.status = ST_TRUNC;
      else if (e != 0 && frm_crc != rx_fcs) r.status = ST_CRC_ERR;
      else if (cfg_type_en && frm_type != cfg_type) r.status = ST_BAD_TYPE;
      else r.status = ST_OK;
      r.frame_type   = frm_type;
      r.frame_len    = frm_cnt;
      r.computed_crc = frm_crc;
      verdict_q.push_back(r);
      frm_cnt   = '0;
      frm_crc   = CRC_INIT;
      magic_hit = 1'b0;
      ver_hit   = 1'b0;
      frm_type  = '0;
      rx_fcs    = '0;
    end
  endtask

  // verdict checker and receiver stalls
  always @(posedge clk) begin : verdict_chk
    res_t exp_r;
    if (rst_n === 1'b1 && out_ch.valid && out_ch.ready) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        $error("unexpected verdict: status %0d len %0d", out_ch.status, out_ch.frame_len);
        err_cnt++;
      end else begin
        exp_r = verdict_q.pop_front();
        if (out_ch.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_ch.status);
          err_cnt++;
        end
        if (out_ch.frame_type !== exp_r.frame_type) begin
          $error("frame_type: expected 0x%02h, got 0x%02h", exp_r.frame_type,
                 out_ch.frame_type);
          err_cnt++;
        end
        if (out_ch.frame_len !== exp_r.frame_len) begin
          $error("frame_len: expected %0d, got %0d", exp_r.frame_len, out_ch.frame_len);
          err_cnt++;
        end
        if (out_ch.computed_crc !== exp_r.computed_crc) begin
          $error("computed_crc: expected 0x%04h, got 0x%04h", exp_r.computed_crc,
                 out_ch.computed_crc);
          err_cnt++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    track_frame_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q, input int from, input int upto);
    for (int i = from; i < upto; i++) send_byte(q[i], i == q.size() - 1);
  endtask

  // sender holds off until every verdict is in and the pipeline has drained
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAGIC:    cfg_magic = val;
      REG_VERSION:  cfg_ver = val;
      REG_EXP_LEN:  cfg_len = val;
      REG_EXP_TYPE: cfg_type = val;
      REG_TYPE_EN:  cfg_type_en = val[0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  function automatic byte_q_t build_frame(input int unsigned n, input fault_t fault);
    byte_q_t q;
    logic [CRC_W-1:0] c;
    int unsigned e;
    int unsigned k;
    e = span_len();
    c = CRC_INIT;
    for (int i = 0; i < n; i++) q.push_back(BYTE_W'($urandom_range(255)));
    if (fault != FLT_NOISE) begin
      q[0] = (fault == FLT_MAGIC) ? ~cfg_magic : cfg_magic;
      if (n > 1) q[1] = (fault == FLT_VER) ? ~cfg_ver : cfg_ver;
      if (n > 2 && fault == FLT_TYPE) q[2] = ~cfg_type;
      else if (n > 2 && (cfg_type_en || $urandom_range(1))) q[2] = cfg_type;
      if (e != 0) begin
        for (int i = 0; i < n && i < e - 2; i++) c = crc_next(c, q[i]);
        if (n > e - 2) q[e-2] = c[7:0];
        if (n > e - 1) q[e-1] = c[15:8];
      end
      if (fault == FLT_BIT) begin
        k = $urandom_range(n - 1);
        q[k] = q[k] ^ (8'h01 << $urandom_range(7));
      end
    end
    return q;
  endfunction

  task automatic send_frame(input int unsigned n, input fault_t fault);
    byte_q_t q;
    q = build_frame(n, fault);
    send_bytes(q, 0, q.size());
  endtask

  task automatic set_idling(input int snd, input int rcv);
    send_idle_pct = snd;
    stall_pct     = rcv;
  endtask

  task automatic test_reset_defaults();
    send_frame(EXP_LEN_RST, FLT_NONE);
  endtask

  task automatic test_header_only();
    write_reg(REG_MAGIC, 8'hFF);
    write_reg(REG_VERSION, 8'h00);
    write_reg(REG_EXP_LEN, 8'h00);
    write_reg(REG_EXP_TYPE, 8'h80);
    write_reg(REG_TYPE_EN, 8'h01);
    send_frame(3, FLT_NONE);
    send_frame(3, FLT_MAGIC);
    send_frame(3, FLT_VER);
    send_frame(4, FLT_TYPE);
    send_frame(1, FLT_NOISE);
    send_frame(2, FLT_NONE);
  endtask

  task automatic test_short_expected_len();
    logic [CRC_W-1:0] c;
    c = crc_next(CRC_INIT, 8'h00);
    write_reg(REG_MAGIC, 8'h00);
    write_reg(REG_VERSION, c[7:0]);
    write_reg(REG_EXP_TYPE, c[15:8]);
    write_reg(REG_EXP_LEN, 8'd1);
    send_frame(3, FLT_NONE);
    send_frame(3, FLT_BIT);
    send_frame(5, FLT_NONE);
    write_reg(REG_EXP_LEN, 8'd2);
    send_frame(3, FLT_NONE);
    write_reg(REG_EXP_LEN, MIN_LEN);
    send_frame(3, FLT_NONE);
  endtask

  task automatic test_unknown_index();
    for (int k = REG_TYPE_EN + 1; k <= IDX_TOP; k++)
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom_range(255)));
    send_frame(MIN_LEN, FLT_NONE);
  endtask

  task automatic test_mid_frame_config();
    byte_q_t q;
    write_reg(REG_MAGIC, CFG_DATA_W'($urandom_range(255)));
    write_reg(REG_VERSION, CFG_DATA_W'($urandom_range(255)));
    write_reg(REG_EXP_LEN, 8'd8);
    write_reg(REG_TYPE_EN, 8'h00);
    q = build_frame(8, FLT_NONE);
    send_bytes(q, 0, 4);
    write_reg(REG_EXP_TYPE, ~q[2]);
    write_reg(REG_TYPE_EN, 8'h01);
    send_bytes(q, 4, q.size());
  endtask

  task automatic test_long_frames();
    set_idling(15, 15);
    write_reg(REG_TYPE_EN, 8'h00);
    write_reg(REG_EXP_LEN, CNT_MAX);
    send_frame(CNT_MAX, FLT_NONE);
    send_frame(CNT_MAX + 7, FLT_NONE);
    set_idling(0, 0);
  endtask

  task automatic test_random_phases();
    int unsigned r;
    int unsigned e;
    int unsigned base;
    int unsigned n;
    int start;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: set_idling(0, 0);
        1: set_idling(75, 0);
        2: set_idling(0, 75);
        default: set_idling(15, 15);
      endcase
      write_reg(REG_MAGIC, CFG_DATA_W'($urandom_range(255)));
      write_reg(REG_VERSION, CFG_DATA_W'($urandom_range(255)));
      write_reg(REG_EXP_TYPE, CFG_DATA_W'($urandom_range(255)));
      write_reg(REG_TYPE_EN, CFG_DATA_W'($urandom_range(255)));
      r = $urandom_range(9);
      write_reg(REG_EXP_LEN, CFG_DATA_W'((r < 4) ? r : $urandom_range(4, 24)));
      start = bytes_sent;
      while (bytes_sent - start < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) wait_quiet();
        e    = span_len();
        base = (e == 0) ? $urandom_range(3, 8) : e;
        r    = $urandom_range(99);
        if (r < 60) send_frame(base, FLT_NONE);
        else if (r < 70) send_frame(base + $urandom_range(1, 4), FLT_NONE);
        else if (r < 78) send_frame($urandom_range(1, base - 1), FLT_NONE);
        else if (r < 88) send_frame(base, FLT_BIT);
        else if (r < 92) send_frame(base, FLT_MAGIC);
        else if (r < 95) send_frame(base, FLT_VER);
        else if (r < 98) send_frame(base, FLT_TYPE);
        else begin
          n = $urandom_range(1, 8);
          send_frame(n, FLT_NOISE);
        end
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_header_only();
    test_short_expected_len();
    test_unknown_index();
    test_mid_frame_config();
    test_long_frames();
    test_random_phases();

    wait_quiet();
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes, checked %0d verdicts over %0d register writes,", bytes_sent,
             verdicts_seen, cfg_writes);
    $display("covering header-only, short, long and saturated frames under idle and stall.");
    if (err_cnt == 0 && verdict_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cfc_pkg.sv
rtl/cfc_in_if.sv
rtl/cfc_out_if.sv
rtl/cfc_cfg_regs.sv
rtl/cfc_frame_track.sv
rtl/crc16_frame_checker.sv
tb/sv/tb_top.sv
